[src/rkvs_pkg.sv]
// Shared types for the row key/value sorter.
// No dependencies; imported by the interface, controller, datapath and top level.
package rkvs_pkg;
   localparam int COLUMN_W  = 31;
   localparam int PAYLOAD_W = 64;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic insert;      // store the req transaction
      logic drop;        // store full: mark row dropped
      logic emit_next;   // rsp transaction taken, advance
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic drain_last;  // output slot holds the final entry
   } status_type;
endpackage

[src/rkvs_if.sv]
// Valid/ready channel interface for the row key/value sorter.
// Depends on rkvs_pkg for field widths.
interface rkvs_req_if;
   import rkvs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [COLUMN_W-1:0]  column;
   logic [PAYLOAD_W-1:0] payload;
   logic                 last;
   modport source (output valid, column, payload, last, input ready);
   modport sink   (input valid, column, payload, last, output ready);
endinterface

interface rkvs_rsp_if;
   import rkvs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [COLUMN_W-1:0]  sorted_column;
   logic [PAYLOAD_W-1:0] sorted_payload;
   logic                 end_of_row;
   logic                 overflow;
   modport source (output valid, sorted_column, sorted_payload, end_of_row, overflow,
                   input ready);
   modport sink   (input valid, sorted_column, sorted_payload, end_of_row, overflow,
                   output ready);
endinterface

[src/rkvs_datapath.sv]
// Systolic insertion chain of key/payload cells plus drain shifting.
// Depends on rkvs_pkg.
module rkvs_datapath #(
   parameter int ROW_CAPACITY = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rkvs_pkg::cmd_type              cmd,
   input  logic [rkvs_pkg::COLUMN_W-1:0]  in_column,
   input  logic [rkvs_pkg::PAYLOAD_W-1:0] in_payload,
   output rkvs_pkg::status_type           status,
   output logic [rkvs_pkg::COLUMN_W-1:0]  out_column,
   output logic [rkvs_pkg::PAYLOAD_W-1:0] out_payload,
   output logic                           out_overflow
);
   import rkvs_pkg::*;
   localparam int CW = $clog2(ROW_CAPACITY + 1);

   logic [COLUMN_W-1:0]  key_ff   [ROW_CAPACITY];
   logic [PAYLOAD_W-1:0] pay_ff   [ROW_CAPACITY];
   logic [CW-1:0]        count_ff, count_in;
   logic                 drop_ff, drop_in;
   logic                 gt       [ROW_CAPACITY];

   // cell i holds sorted entry i; occupied when i < count
   always_comb begin
      for (int i = 0; i < ROW_CAPACITY; i++) begin
         gt[i] = (CW'(i) < count_ff) && (key_ff[i] > in_column);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROW_CAPACITY; i++) begin
         if (cmd.insert) begin
            if (i == 0) begin
               if (gt[0] || count_ff == '0) begin
                  key_ff[0] <= in_column;
                  pay_ff[0] <= in_payload;
               end
            end else if (gt[i-1]) begin
               key_ff[i] <= key_ff[i-1];
               pay_ff[i] <= pay_ff[i-1];
            end else if (gt[i] || CW'(i) == count_ff) begin
               key_ff[i] <= in_column;
               pay_ff[i] <= in_payload;
            end
         end else if (cmd.emit_next && i < ROW_CAPACITY - 1) begin
            key_ff[i] <= key_ff[i+1];
            pay_ff[i] <= pay_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (cmd.insert) count_in = count_ff + CW'(1);
      if (cmd.drop)   drop_in  = 1'b1;
      if (cmd.emit_next) begin
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) drop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   assign status.full       = (count_ff == CW'(ROW_CAPACITY));
   assign status.drain_last = (count_ff == CW'(1));
   assign out_column        = key_ff[0];
   assign out_payload       = pay_ff[0];
   assign out_overflow      = drop_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ROW_CAPACITY)) else $error("count above capacity");
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !status.full) else $error("insert into full store");
   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_next && count_ff == CW'(1) |=> count_ff == '0 && !drop_ff)
      else $error("row state not cleared");
`endif
endmodule

[src/rkvs_ctrl.sv]
// Controller: collect phase, then drain phase for one row.
// Depends on rkvs_pkg.
module rkvs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 end_of_row,
   input  rkvs_pkg::status_type status,
   output rkvs_pkg::cmd_type    cmd
);
   import rkvs_pkg::*;
   state_type state_ff, state_in;
   logic      take;

   assign take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: if (take && req_last) state_in = ST_EMIT;
         ST_EMIT:    if (rsp_ready && status.drain_last) state_in = ST_COLLECT;
         default:    state_in = ST_COLLECT;
      endcase
   end

   // req_ready is high for the whole collect state, so req_valid alone marks a take
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready      = 1'b1;
            cmd.insert     = req_valid && !status.full;
            cmd.drop       = req_valid && status.full;
         end
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_next = rsp_ready;
         end
         default: ;
      endcase
   end

   assign end_of_row = status.drain_last;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_COLLECT;
      else       state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("both phases active");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset)) else $error("emit right after reset");
   a_leave: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && end_of_row |=> req_ready) else $error("stuck in drain");
`endif
endmodule

[src/row_key_value_sort.sv]
// Top level of the row key/value sorter: controller plus insertion-chain datapath.
// Depends on rkvs_pkg, rkvs_if, rkvs_ctrl, rkvs_datapath.
//
//  channel | dir | transaction
//  req     | in  | column, payload, last (one row entry)
//  rsp     | out | sorted_column, sorted_payload, end_of_row, overflow
//
// Collect: one req transaction per cycle; each entry drops into its sorted
//   place in the cell chain in the same cycle (compare in every cell).
// Drain: after last, the row leaves one rsp transaction per cycle from cell 0,
//   the chain shifting down; req is held off until the row is out.
// rsp stalls simply freeze the chain. Entries beyond ROW_CAPACITY are dropped
//   and overflow is set on every result of that row.
// Reset (synchronous, active high) empties the store and returns to collect.
module row_key_value_sort #(
   parameter int ROW_CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   rkvs_req_if.sink   req,
   rkvs_rsp_if.source rsp
);
   import rkvs_pkg::*;
   cmd_type    cmd;
   status_type status;

   rkvs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_last   (req.last),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .end_of_row (rsp.end_of_row),
      .status     (status),
      .cmd        (cmd)
   );

   rkvs_datapath #(.ROW_CAPACITY(ROW_CAPACITY)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .in_column    (req.column),
      .in_payload   (req.payload),
      .status       (status),
      .out_column   (rsp.sorted_column),
      .out_payload  (rsp.sorted_payload),
      .out_overflow (rsp.overflow)
   );
endmodule
